// ----- sv/pn2d_pkg.sv -----
// pn2d_pkg: shared types and constants for the 2d gradient noise block
// no dependencies

package pn2d_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam int ONE_Q16 = 65536;

	// command passed from front end to back end through the queue
	typedef struct packed {
		logic        eval;
		logic [15:0] addr;
		logic [31:0] grad;
		logic [31:0] x_coord;
		logic [31:0] y_coord;
	} pn2d_cmd_t;

endpackage

// ----- sv/pn2d_front.sv -----
// pn2d_front: input stage and two-entry command queue
// depends on pn2d_pkg

module pn2d_front import pn2d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  table_row,
	input  logic [7:0]  table_column,
	input  logic [15:0] gradient_x,
	input  logic [15:0] gradient_y,
	input  logic [31:0] x_coord,
	input  logic [31:0] y_coord,
	output logic        cmd_valid,
	input  logic        cmd_take,
	output pn2d_cmd_t   cmd
);

	pn2d_cmd_t   buf_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q].eval    <= (operation == OP_EVAL);
			buf_q[wr_q].addr    <= {table_row, table_column};
			buf_q[wr_q].grad    <= {gradient_y, gradient_x};
			buf_q[wr_q].x_coord <= x_coord;
			buf_q[wr_q].y_coord <= y_coord;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (cmd_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_take};
		end
	end

endmodule

// ----- sv/pn2d_back.sv -----
// pn2d_back: gradient table memory, four-corner sequencer, arithmetic datapath
// depends on pn2d_pkg

module pn2d_back import pn2d_pkg::*; #(
	parameter int GRID = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_take,
	input  pn2d_cmd_t   cmd,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] noise_value
);

	localparam int GM1 = GRID - 1;
	// reciprocal of GRID-1, exact quotient for every 16-bit cell index
	localparam logic [23:0] RECIP = 24'((1 << 24) / GM1 + 1);

	logic [31:0] mem [65536];
	logic [31:0] rd_s1;

	// sequencer: phases 0..3 read corners, dot products land in 1..4,
	// blend in 6..8, saturate in 9 (held while the last result waits), done in 10
	logic        busy_q;
	logic [3:0]  ph_q;
	logic [7:0]  c0_q, c1_q, r0_q, r1_q;
	logic [16:0] fx_q, fy_q;
	logic [1:0]  cs1_q;
	logic        rdv_s1;
	logic signed [33:0] n_q [4];
	logic signed [33:0] sx_q, sy_q;
	logic [16:0] tx2_q, ty2_q;
	logic        res_pend_q;
	logic [15:0] res_q;

	// cell index mod (GRID-1), quotient by reciprocal multiply
	function automatic logic [7:0] mod_gm1(input logic [15:0] v);
		logic [39:0] p;
		logic [23:0] qd;
		p  = 40'(v) * 40'(RECIP);
		qd = 24'(p[39:24]) * 24'(GM1);
		return 8'(24'(v) - qd);
	endfunction

	logic start;
	assign start    = cmd_valid && !busy_q;
	assign cmd_take = start;

	// saturate step waits while the previous result still sits in the output register
	logic hold;
	assign hold = (ph_q == 4'd9) && res_pend_q && out_stall;

	logic [15:0] rd_addr;
	always_comb begin
		unique case (ph_q[1:0])
			2'd0: rd_addr = {r0_q, c0_q};
			2'd1: rd_addr = {r0_q, c1_q};
			2'd2: rd_addr = {r1_q, c0_q};
			default: rd_addr = {r1_q, c1_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && !cmd.eval) mem[cmd.addr] <= cmd.grad;
		rd_s1 <= mem[rd_addr];
	end

	// dot product for the corner read last cycle
	logic signed [17:0] dx, dy;
	logic signed [33:0] px, py;
	always_comb begin
		dx = cs1_q[0] ? $signed({1'b0, fx_q}) - 18'sd65536 : $signed({1'b0, fx_q});
		dy = cs1_q[1] ? $signed({1'b0, fy_q}) - 18'sd65536 : $signed({1'b0, fy_q});
		px = dx * $signed(rd_s1[15:0]);
		py = dy * $signed(rd_s1[31:16]);
	end

	// blend datapath, one multiply per cycle
	logic signed [33:0] a0, a1, s, diff, bl;
	logic signed [51:0] prod;
	logic [3:0] bph;
	always_comb begin
		a0 = n_q[0]; a1 = n_q[1]; s = sx_q;
		unique case (bph)
			4'd0: begin a0 = n_q[0]; a1 = n_q[1]; s = sx_q; end
			4'd1: begin a0 = n_q[2]; a1 = n_q[3]; s = sx_q; end
			default: begin a0 = n_q[0]; a1 = n_q[2]; s = sy_q; end
		endcase
		diff = a1 - a0;
		prod = 52'(diff) * 52'(s);
		bl   = a0 + 34'(prod >>> 16);
	end

	logic signed [34:0] vh;
	always_comb vh = (35'(n_q[0]) + 35'sd65536) >>> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			ph_q       <= 4'd0;
			rdv_s1     <= 1'b0;
			res_pend_q <= 1'b0;
		end else begin
			if (res_pend_q && !out_stall) res_pend_q <= 1'b0;
			rdv_s1 <= busy_q && ph_q < 4'd4;
			if (start && cmd.eval) begin
				busy_q <= 1'b1;
				ph_q   <= 4'd0;
			end else if (busy_q && !hold) begin
				ph_q <= ph_q + 4'd1;
				if (ph_q == 4'd10) begin
					busy_q     <= 1'b0;
					res_pend_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && cmd.eval) begin
			c0_q  <= mod_gm1(cmd.x_coord[31:16]);
			r0_q  <= mod_gm1(cmd.y_coord[31:16]);
			fx_q  <= {1'b0, cmd.x_coord[15:0]};
			fy_q  <= {1'b0, cmd.y_coord[15:0]};
		end
		// next cell wraps to zero past the last cell index (GRID-2) of a column or row
		if (busy_q && ph_q == 4'd0) begin
			c1_q <= (c0_q == 8'(GM1 - 1)) ? 8'd0 : c0_q + 8'd1;
			r1_q <= (r0_q == 8'(GM1 - 1)) ? 8'd0 : r0_q + 8'd1;
		end
		cs1_q <= ph_q[1:0];
		if (rdv_s1) begin
			n_q[cs1_q] <= (px >>> 14) + (py >>> 14);
		end
		// smoothstep, spread across phases
		unique case (ph_q)
			4'd1: begin
				tx2_q <= 17'((34'(fx_q) * 34'(fx_q)) >> 16);
				ty2_q <= 17'((34'(fy_q) * 34'(fy_q)) >> 16);
			end
			4'd2: begin
				sx_q <= 34'((36'(tx2_q) * (36'd196608 - 36'(fx_q << 1))) >> 16);
				sy_q <= 34'((36'(ty2_q) * (36'd196608 - 36'(fy_q << 1))) >> 16);
			end
			4'd6: n_q[0] <= bl;
			4'd7: n_q[2] <= bl;
			4'd8: n_q[0] <= bl;
			4'd9: begin
				if (!hold) begin
					if (vh < 0) res_q <= 16'd0;
					else if (vh > 35'sd65535) res_q <= 16'hFFFF;
					else res_q <= vh[15:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (ph_q)
			4'd6: bph = 4'd0;
			4'd7: bph = 4'd1;
			default: bph = 4'd2;
		endcase
	end

	assign out_valid   = res_pend_q;
	assign noise_value = res_q;

endmodule

// ----- sv/perlin_noise_2d.sv -----
// perlin_noise_2d: top level of the 2d gradient noise block
// depends on pn2d_pkg, pn2d_front, pn2d_back
//
// channel | signals                                     | direction
// in      | in_valid/in_stall, operation..y_coord       | into block
// out     | out_valid/out_stall, noise_value            | out of block
//
// a load writes the table as it is taken and leaves the back end free; an evaluate
// holds the table port for four corner reads and then the blend multiplier, and the
// back end takes no new command until that evaluate is done
// the gradient table read port and shared blend multiplier keep evaluates apart
// a two-entry queue lets the front accept while the back end is busy
// a result stalled at the output holds the next evaluate in its saturate step
// reset clears control only; table contents are undefined until loaded

module perlin_noise_2d import pn2d_pkg::*; #(
	parameter int GRID = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  table_row,
	input  logic [7:0]  table_column,
	input  logic [15:0] gradient_x,
	input  logic [15:0] gradient_y,
	input  logic [31:0] x_coord,
	input  logic [31:0] y_coord,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] noise_value
);

	logic      cmd_valid, cmd_take;
	pn2d_cmd_t cmd;

	// front end: accept and queue transactions
	pn2d_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .operation, .table_row,
		.table_column, .gradient_x, .gradient_y, .x_coord, .y_coord,
		.cmd_valid, .cmd_take, .cmd
	);

	// back end: table and arithmetic
	pn2d_back #(.GRID(GRID)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.out_valid, .out_stall, .noise_value
	);

`ifndef ASSERT_OFF
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("queue read while empty");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(noise_value))
		else $error("result dropped under stall");
`endif

endmodule
